@@ rtl/core/rtmp_pkg.sv @@
// Shared types and constants for the recurrence term by matrix power block.
package rtmp_pkg;

  // Fixed field widths of the ports
  localparam int EXP_W     = 31;
  localparam int REG_W     = 10;
  localparam int RESULT_W  = 10;
  localparam int CFG_IDX_W = 3;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] IDX_COEF_FIRST   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] IDX_COEF_SECOND  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] IDX_SEED_UPPER   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] IDX_SEED_LOWER   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] IDX_FINAL_OFFSET = 3'd4;

  // Reset values of the configuration registers
  localparam logic [REG_W-1:0] RST_COEF_FIRST   = 10'd6;
  localparam logic [REG_W-1:0] RST_COEF_SECOND  = 10'd996;
  localparam logic [REG_W-1:0] RST_SEED_UPPER   = 10'd28;
  localparam logic [REG_W-1:0] RST_SEED_LOWER   = 10'd6;
  localparam logic [REG_W-1:0] RST_FINAL_OFFSET = 10'd1;

  typedef struct packed {
    logic [REG_W-1:0] coef_first;
    logic [REG_W-1:0] coef_second;
    logic [REG_W-1:0] seed_upper;
    logic [REG_W-1:0] seed_lower;
    logic [REG_W-1:0] final_offset;
  } cfg_regs_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_CHECK,
    ST_MULT,
    ST_SQUARE,
    ST_FINAL,
    ST_DRAIN
  } state_t;

  // Last step of each burst on the shared multiply-mod unit
  localparam logic [3:0] K_LOAD_END = 4'd8;
  localparam logic [3:0] K_MAT_END  = 4'd11;
  localparam logic [3:0] K_FIN_END  = 4'd12;

endpackage

@@ rtl/core/rtmp_cfg_regs.sv @@
// Configuration register file with its write port.
module rtmp_cfg_regs (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [rtmp_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [rtmp_pkg::REG_W-1:0]        cfg_data,
  output rtmp_pkg::cfg_regs_t               regs
);
  import rtmp_pkg::*;

  cfg_regs_t regs_r;
  cfg_regs_t regs_nxt;

  assign cfg_ready = 1'b1;
  assign regs      = regs_r;

  always_comb begin
    regs_nxt = regs_r;
    if (cfg_valid) begin
      case (cfg_index)
        IDX_COEF_FIRST:   regs_nxt.coef_first   = cfg_data;
        IDX_COEF_SECOND:  regs_nxt.coef_second  = cfg_data;
        IDX_SEED_UPPER:   regs_nxt.seed_upper   = cfg_data;
        IDX_SEED_LOWER:   regs_nxt.seed_lower   = cfg_data;
        IDX_FINAL_OFFSET: regs_nxt.final_offset = cfg_data;
        default:          regs_nxt = regs_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      regs_r.coef_first   <= RST_COEF_FIRST;
      regs_r.coef_second  <= RST_COEF_SECOND;
      regs_r.seed_upper   <= RST_SEED_UPPER;
      regs_r.seed_lower   <= RST_SEED_LOWER;
      regs_r.final_offset <= RST_FINAL_OFFSET;
    end else begin
      regs_r <= regs_nxt;
    end
  end

endmodule

@@ rtl/core/rtmp_mulmod.sv @@
// Pipelined multiply-add-mod unit: res = (a*b + c) mod MODULUS.
module rtmp_mulmod #(
  parameter int  MODULUS = 1000,
  localparam int RES_W   = $clog2(MODULUS),
  localparam int C_W     = $clog2(MODULUS + 1),
  localparam int OP_W    = (RES_W > rtmp_pkg::REG_W) ? RES_W : rtmp_pkg::REG_W
) (
  input  logic             clk,
  input  logic [OP_W-1:0]  in_a,
  input  logic [OP_W-1:0]  in_b,
  input  logic [C_W-1:0]   in_c,
  output logic [RES_W-1:0] res
);
  import rtmp_pkg::*;

  // a*b + c stays below 2^P_W for every operand pattern
  localparam int                P_W     = 2 * OP_W + 1;
  localparam longint unsigned   RECIP_L = (64'd1 << P_W) / MODULUS;
  localparam logic [P_W-1:0]    RECIP   = P_W'(RECIP_L);
  localparam logic [C_W-1:0]    MOD_C   = C_W'(MODULUS);

  logic [P_W-1:0]       p_r, p_nxt;
  logic [P_W-1:0]       p2_r;
  logic [P_W-1:0]       q_r, q_nxt;
  logic [C_W:0]         r_r, r_nxt;
  logic [RES_W-1:0]     res_r, res_nxt;
  logic [2*P_W-1:0]     prod;
  logic [P_W+C_W-1:0]   qm_full;
  logic [P_W-1:0]       r_full;

  // Stage 0: product plus addend
  assign p_nxt = P_W'(in_a) * P_W'(in_b) + P_W'(in_c);

  // Stage 1: quotient estimate, floor(p/M) or one below
  assign prod  = (2*P_W)'(p_r) * (2*P_W)'(RECIP);
  assign q_nxt = prod[2*P_W-1:P_W];

  // Stage 2: partial remainder, below 2*M
  assign qm_full = (P_W+C_W)'(q_r) * (P_W+C_W)'(MOD_C);
  assign r_full  = p2_r - qm_full[P_W-1:0];
  assign r_nxt   = r_full[C_W:0];

  // Stage 3: final correction
  assign res_nxt = (r_r >= {1'b0, MOD_C}) ? RES_W'(r_r - {1'b0, MOD_C}) : RES_W'(r_r);

  always_ff @(posedge clk) begin
    p_r   <= p_nxt;
    p2_r  <= p_r;
    q_r   <= q_nxt;
    r_r   <= r_nxt;
    res_r <= res_nxt;
  end

  assign res = res_r;

endmodule

@@ rtl/core/recurrence_term_by_matrix_power.sv @@
// Top level: second-order recurrence term by companion matrix power, modulo MODULUS.
//
//   channel  | direction | handshake             | payload
//   ---------+-----------+-----------------------+-----------------------------
//   in_      | input     | in_valid / in_stall   | in_exponent   [30:0]
//   out_     | output    | out_valid / out_stall | out_residue   [9:0]
//   cfg_     | input     | cfg_valid / cfg_ready | cfg_index [2:0], cfg_data [9:0]
//
// One transaction at a time. All arithmetic runs on the single four-stage
// multiply-mod unit; each 2x2 matrix product is a burst on it.
// rst_n is synchronous, active low; it clears control state and restores the
// configuration registers. in_stall is high from acceptance until the result is
// handed to the output register; out_stall holds the result in that register.
module recurrence_term_by_matrix_power #(
  parameter int MODULUS  = 1000,
  parameter int EXP_BITS = 31
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [rtmp_pkg::EXP_W-1:0]        in_exponent,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [rtmp_pkg::RESULT_W-1:0]     out_residue,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [rtmp_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [rtmp_pkg::REG_W-1:0]        cfg_data
);
  import rtmp_pkg::*;

  localparam int RES_W = $clog2(MODULUS);
  localparam int C_W   = $clog2(MODULUS + 1);
  localparam int OP_W  = (RES_W > REG_W) ? RES_W : REG_W;
  // Only the low EXP_BITS bits of n-1 take part; the port caps it at EXP_W
  localparam int NBITS = (EXP_BITS < EXP_W) ? EXP_BITS : EXP_W;
  localparam logic [C_W-1:0] MOD_C = C_W'(MODULUS);

  cfg_regs_t regs;

  state_t state_r, state_nxt;
  logic [3:0]        k_r, k_nxt;
  logic [NBITS-1:0]  e_r, e_nxt;
  logic [RES_W-1:0]  acc_r  [4];
  logic [RES_W-1:0]  acc_nxt[4];
  logic [RES_W-1:0]  base_r  [4];
  logic [RES_W-1:0]  base_nxt[4];
  logic [RES_W-1:0]  su_r, su_nxt;
  logic [RES_W-1:0]  sl_r, sl_nxt;
  logic [RES_W-1:0]  off_r, off_nxt;
  logic [RES_W-1:0]  fin_r, fin_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [RESULT_W-1:0] out_residue_r, out_residue_nxt;

  logic              accept;
  logic              out_free;
  logic [1:0]        j;
  logic [RES_W-1:0]  mat_a[4];
  logic [REG_W-1:0]  reg_sel;
  logic [OP_W-1:0]   mm_a, mm_b;
  logic [C_W-1:0]    mm_c;
  logic [RES_W-1:0]  mm_res;

  rtmp_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .regs      (regs)
  );

  rtmp_mulmod #(.MODULUS(MODULUS)) u_mulmod (
    .clk  (clk),
    .in_a (mm_a),
    .in_b (mm_b),
    .in_c (mm_c),
    .res  (mm_res)
  );

  assign in_stall    = (state_r != ST_IDLE);
  assign accept      = in_valid && !in_stall;
  assign out_valid   = out_valid_r;
  assign out_residue = out_residue_r;
  assign out_free    = !out_valid_r || !out_stall;
  // Matrix element index within a burst; bursts are aligned to multiples of four
  assign j           = k_r[1:0];

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:   if (accept) state_nxt = ST_LOAD;
      ST_LOAD:   if (k_r == K_LOAD_END) state_nxt = ST_CHECK;
      ST_CHECK: begin
        if (e_r == '0)      state_nxt = ST_FINAL;
        else if (e_r[0])    state_nxt = ST_MULT;
        else                state_nxt = ST_SQUARE;
      end
      ST_MULT: begin
        // Skip the square when no exponent bit remains above this one
        if (k_r == K_MAT_END) state_nxt = ((e_r >> 1) == '0) ? ST_FINAL : ST_SQUARE;
      end
      ST_SQUARE: if (k_r == K_MAT_END) state_nxt = ST_CHECK;
      ST_FINAL:  if (k_r == K_FIN_END) state_nxt = ST_DRAIN;
      ST_DRAIN:  if (out_free) state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  // Operand select for the shared unit
  always_comb begin
    mm_a = '0;
    mm_b = '0;
    mm_c = '0;
    for (int i = 0; i < 4; i++) begin
      mat_a[i] = (state_r == ST_SQUARE) ? base_r[i] : acc_r[i];
    end
    case (k_r[2:0])
      3'd0:    reg_sel = regs.coef_first;
      3'd1:    reg_sel = regs.coef_second;
      3'd2:    reg_sel = regs.seed_upper;
      3'd3:    reg_sel = regs.seed_lower;
      default: reg_sel = regs.final_offset;
    endcase
    case (state_r)
      ST_LOAD: begin
        // Reduce each register: reg * 1 + 0
        mm_a = OP_W'(reg_sel);
        mm_b = OP_W'(1);
      end
      ST_MULT, ST_SQUARE: begin
        if (!k_r[2]) begin
          mm_a = OP_W'(mat_a[{j[1], 1'b0}]);
          mm_b = OP_W'(base_r[{1'b0, j[0]}]);
        end else begin
          // Second term of the dot product, first term fed back as addend
          mm_a = OP_W'(mat_a[{j[1], 1'b1}]);
          mm_b = OP_W'(base_r[{1'b1, j[0]}]);
          mm_c = C_W'(mm_res);
        end
      end
      ST_FINAL: begin
        case (k_r[3:2])
          2'd0: begin
            mm_a = OP_W'(su_r);
            mm_b = OP_W'(acc_r[2]);
          end
          2'd1: begin
            mm_a = OP_W'(sl_r);
            mm_b = OP_W'(acc_r[3]);
            mm_c = C_W'(mm_res);
          end
          default: begin
            // Subtract the offset by adding its complement
            mm_a = OP_W'(mm_res);
            mm_b = OP_W'(1);
            mm_c = MOD_C - C_W'(off_r);
          end
        endcase
      end
      default: begin
        mm_a = '0;
      end
    endcase
  end

  // Datapath and counters
  always_comb begin
    k_nxt    = (state_nxt != state_r) ? 4'd0 : k_r + 4'd1;
    e_nxt    = e_r;
    acc_nxt  = acc_r;
    base_nxt = base_r;
    su_nxt   = su_r;
    sl_nxt   = sl_r;
    off_nxt  = off_r;
    fin_nxt  = fin_r;
    out_valid_nxt   = out_valid_r && out_stall;
    out_residue_nxt = out_residue_r;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          // n-1 saturating at zero, low NBITS bits only
          e_nxt = (in_exponent == '0) ? '0 : NBITS'(in_exponent - EXP_W'(1));
        end
      end
      ST_LOAD: begin
        case (k_r)
          4'd4: base_nxt[0] = mm_res;
          4'd5: base_nxt[1] = mm_res;
          4'd6: su_nxt      = mm_res;
          4'd7: sl_nxt      = mm_res;
          4'd8: begin
            off_nxt     = mm_res;
            base_nxt[2] = RES_W'(1);
            base_nxt[3] = '0;
            acc_nxt[0]  = RES_W'(1);
            acc_nxt[1]  = '0;
            acc_nxt[2]  = '0;
            acc_nxt[3]  = RES_W'(1);
          end
          default: off_nxt = off_r;
        endcase
      end
      ST_MULT: begin
        if (k_r[3]) acc_nxt[j] = mm_res;
      end
      ST_SQUARE: begin
        if (k_r[3]) base_nxt[j] = mm_res;
        if (k_r == K_MAT_END) e_nxt = e_r >> 1;
      end
      ST_FINAL: begin
        if (k_r == K_FIN_END) fin_nxt = mm_res;
      end
      ST_DRAIN: begin
        if (out_free) begin
          out_valid_nxt   = 1'b1;
          out_residue_nxt = RESULT_W'(fin_r);
        end
      end
      default: e_nxt = e_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      k_r         <= '0;
      out_valid_r <= 1'b0;
    end else begin
      k_r         <= k_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    e_r           <= e_nxt;
    acc_r         <= acc_nxt;
    base_r        <= base_nxt;
    su_r          <= su_nxt;
    sl_r          <= sl_nxt;
    off_r         <= off_nxt;
    fin_r         <= fin_nxt;
    out_residue_r <= out_residue_nxt;
  end

  // A new result appears only out of the drain step
  a_rise_from_drain: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) == ST_DRAIN)
    else $error("result raised outside drain step");

  // An accepted transaction starts its load burst from step zero
  a_accept_load: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> (state_r == ST_LOAD && k_r == 4'd0))
    else $error("accepted transaction did not start load");

  // Matrix entries stay reduced while the exponent walk runs
  a_acc_reduced: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_CHECK) |->
      (int'(acc_r[0]) < MODULUS && int'(acc_r[3]) < MODULUS &&
       int'(base_r[0]) < MODULUS && int'(base_r[1]) < MODULUS))
    else $error("matrix entry out of range");

  // Delivered residue is reduced unless the field masks it
  a_out_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (MODULUS > 1024 || int'(out_residue_r) < MODULUS))
    else $error("residue out of range");

endmodule
